// File: rtl/rf433_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf433_pkg
// Widths, codes and reset values shared by the tri-state code decoder.
// ----------------------------------------------------------------------------
package rf433_pkg;

  localparam int PULSE_W = 16;
  localparam int CFG_W   = 16;
  localparam int CNT_W   = 6;
  localparam int CODE_W  = 24;
  localparam int CHAN_N  = 5;

  localparam logic [CNT_W-1:0] FRAME_LEN = 6'd49;
  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;
  localparam logic [CNT_W-1:0] LAST_IDX  = 6'd48;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC_MIN  = 2'd0,
    CFG_SYNC_MAX  = 2'd1,
    CFG_LONG_THR  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] SYNC_MIN_RST = 16'd9331;
  localparam logic [CFG_W-1:0] SYNC_MAX_RST = 16'd12399;
  localparam logic [CFG_W-1:0] LONG_THR_RST = 16'd700;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_LENGTH  = 3'd1,
    ST_BAD_SYNC    = 3'd2,
    ST_BAD_SYMBOL  = 3'd3,
    ST_BAD_CHANNEL = 3'd4,
    ST_BAD_BUTTON  = 3'd5,
    ST_BAD_POWER   = 3'd6
  } status_t;

  // button patterns, ten code bits
  localparam logic [9:0] BTN_A = 10'b0001010101;
  localparam logic [9:0] BTN_B = 10'b0100010101;
  localparam logic [9:0] BTN_C = 10'b0101000101;
  localparam logic [9:0] BTN_D = 10'b0101010001;
  localparam logic [9:0] BTN_E = 10'b0101010100;

  localparam logic [2:0] BTN_IDX_A = 3'd0;
  localparam logic [2:0] BTN_IDX_B = 3'd1;
  localparam logic [2:0] BTN_IDX_C = 3'd2;
  localparam logic [2:0] BTN_IDX_D = 3'd3;
  localparam logic [2:0] BTN_IDX_E = 3'd4;

  localparam logic [3:0] PWR_ON  = 4'b0001;
  localparam logic [3:0] PWR_OFF = 4'b0100;

  localparam logic [1:0] PAIR_TRUE  = 2'b00;
  localparam logic [1:0] PAIR_FALSE = 2'b01;

  typedef struct packed {
    status_t           status;
    logic [CHAN_N-1:0] channel_bits;
    logic [2:0]        button;
    logic              power_on;
  } result_t;

endpackage

// File: rtl/rf433_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf433 channel interfaces
// Valid/ready channels for pulse beats in and decoded frame results out.
// ----------------------------------------------------------------------------
interface rf433_in_if;
  logic                           valid;
  logic                           ready;
  logic [rf433_pkg::PULSE_W-1:0]  pulse_us;
  logic                           frame_end;

  modport source (output valid, output pulse_us, output frame_end, input ready);
  modport sink   (input valid, input pulse_us, input frame_end, output ready);
endinterface

interface rf433_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     status;
  logic [rf433_pkg::CHAN_N-1:0]   channel_bits;
  logic [2:0]                     button;
  logic                           power_on;

  modport source (output valid, output status, output channel_bits, output button,
                  output power_on, input ready);
  modport sink   (input valid, input status, input channel_bits, input button,
                  input power_on, output ready);
endinterface

// File: rtl/rf433_tristate_code_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf433_tristate_code_decoder_core
// Decodes a tri-state remote frame from a stream of pulse durations. One
// pulse beat is taken every cycle while in_ch.ready is high; the beat
// marked frame_end yields a result beat (status, channel bits, button,
// power) in the result register, or in the skid register while that waits.
// The rate is set by the per-beat frame state update, a single register
// stage; a two-deep output buffer (result register plus skid register) lets
// input flow while a result waits; input stalls only when both hold results.
// ----------------------------------------------------------------------------
module rf433_tristate_code_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  rf433_in_if.sink                      in_ch,
  rf433_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [rf433_pkg::CFG_W-1:0]   cfg_wdata
);

  // configuration
  logic [rf433_pkg::CFG_W-1:0] sync_min_r, sync_max_r, long_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_min_r <= rf433_pkg::SYNC_MIN_RST;
      sync_max_r <= rf433_pkg::SYNC_MAX_RST;
      long_thr_r <= rf433_pkg::LONG_THR_RST;
    end else if (cfg_we) begin
      unique case (rf433_pkg::cfg_idx_t'(cfg_index))
        rf433_pkg::CFG_SYNC_MIN: sync_min_r <= cfg_wdata;
        rf433_pkg::CFG_SYNC_MAX: sync_max_r <= cfg_wdata;
        rf433_pkg::CFG_LONG_THR: long_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame state
  logic [rf433_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                         sync_ok_r, sync_ok_nxt;
  logic                         first_long_r, first_long_nxt;
  logic                         sym_err_r, sym_err_nxt;
  logic [rf433_pkg::CODE_W-1:0] code_r, code_nxt;

  logic accept;
  logic skid_v_r;
  logic out_v_r;
  rf433_pkg::result_t out_r, skid_r, res;

  assign in_ch.ready = !skid_v_r;
  assign accept      = in_ch.valid && in_ch.ready;

  logic idx_first, idx_in_frame, idx_odd;
  logic second_long;

  always_comb begin
    idx_first    = (count_r == '0);
    idx_in_frame = (count_r <= rf433_pkg::LAST_IDX) && !idx_first;
    idx_odd      = count_r[0];
    second_long  = (in_ch.pulse_us >= long_thr_r);

    sync_ok_nxt    = sync_ok_r;
    first_long_nxt = first_long_r;
    sym_err_nxt    = sym_err_r;
    code_nxt       = code_r;
    if (idx_first) begin
      sync_ok_nxt = (in_ch.pulse_us >= sync_min_r) && (in_ch.pulse_us <= sync_max_r);
    end else if (idx_in_frame) begin
      if (idx_odd) begin
        first_long_nxt = (in_ch.pulse_us > long_thr_r);
      end else begin
        if (first_long_r == second_long) begin
          sym_err_nxt = 1'b1;
        end
        code_nxt = {code_r[rf433_pkg::CODE_W-2:0], first_long_r};
      end
    end
    count_nxt = (count_r == rf433_pkg::COUNT_MAX) ? count_r
                                                  : count_r + rf433_pkg::CNT_W'(1);
  end

  // decode of the frame as it stands after this beat
  logic [rf433_pkg::CHAN_N-1:0] chans;
  logic                         chan_bad;
  logic [2:0]                   btn_idx;
  logic                         btn_bad;
  logic [1:0]                   pair;

  always_comb begin
    chans    = '0;
    chan_bad = 1'b0;
    for (int k = 0; k < rf433_pkg::CHAN_N; k++) begin
      pair = code_nxt[rf433_pkg::CODE_W-1-2*k -: 2];
      if (pair == rf433_pkg::PAIR_TRUE) begin
        chans[k] = 1'b1;
      end else if (pair != rf433_pkg::PAIR_FALSE) begin
        chan_bad = 1'b1;
      end
    end

    btn_bad = 1'b0;
    unique case (code_nxt[13:4])
      rf433_pkg::BTN_A: btn_idx = rf433_pkg::BTN_IDX_A;
      rf433_pkg::BTN_B: btn_idx = rf433_pkg::BTN_IDX_B;
      rf433_pkg::BTN_C: btn_idx = rf433_pkg::BTN_IDX_C;
      rf433_pkg::BTN_D: btn_idx = rf433_pkg::BTN_IDX_D;
      rf433_pkg::BTN_E: btn_idx = rf433_pkg::BTN_IDX_E;
      default: begin
        btn_idx = rf433_pkg::BTN_IDX_A;
        btn_bad = 1'b1;
      end
    endcase

    res = '0;
    priority if (count_nxt != rf433_pkg::FRAME_LEN) begin
      res.status = rf433_pkg::ST_BAD_LENGTH;
    end else if (!sync_ok_nxt) begin
      res.status = rf433_pkg::ST_BAD_SYNC;
    end else if (sym_err_nxt) begin
      res.status = rf433_pkg::ST_BAD_SYMBOL;
    end else if (chan_bad) begin
      res.status = rf433_pkg::ST_BAD_CHANNEL;
    end else if (btn_bad) begin
      res.status = rf433_pkg::ST_BAD_BUTTON;
    end else if (code_nxt[3:0] == rf433_pkg::PWR_ON) begin
      res.status       = rf433_pkg::ST_OK;
      res.channel_bits = chans;
      res.button       = btn_idx;
      res.power_on     = 1'b1;
    end else if (code_nxt[3:0] == rf433_pkg::PWR_OFF) begin
      res.status       = rf433_pkg::ST_OK;
      res.channel_bits = chans;
      res.button       = btn_idx;
    end else begin
      res.status = rf433_pkg::ST_BAD_POWER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      sync_ok_r    <= 1'b0;
      first_long_r <= 1'b0;
      sym_err_r    <= 1'b0;
      code_r       <= '0;
    end else if (accept) begin
      if (in_ch.frame_end) begin
        count_r      <= '0;
        sync_ok_r    <= 1'b0;
        first_long_r <= 1'b0;
        sym_err_r    <= 1'b0;
        code_r       <= '0;
      end else begin
        count_r      <= count_nxt;
        sync_ok_r    <= sync_ok_nxt;
        first_long_r <= first_long_nxt;
        sym_err_r    <= sym_err_nxt;
        code_r       <= code_nxt;
      end
    end
  end

  // output register with skid
  logic res_v, out_fire, out_free;
  assign res_v    = accept && in_ch.frame_end;
  assign out_fire = out_v_r && out_ch.ready;
  assign out_free = !out_v_r || out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r  <= skid_v_r || res_v;
      skid_v_r <= skid_v_r && res_v;
    end else if (res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : res;
      if (skid_v_r && res_v) begin
        skid_r <= res;
      end
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.channel_bits = out_r.channel_bits;
  assign out_ch.button       = out_r.button;
  assign out_ch.power_on     = out_r.power_on;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a beat while output register is empty");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.status != rf433_pkg::ST_OK) |->
      (out_r.channel_bits == '0 && out_r.button == '0 && !out_r.power_on))
    else $error("error result carries nonzero fields");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.frame_end) |=> (count_r == '0 && code_r == '0 && !sym_err_r))
    else $error("frame state not cleared after frame end");

endmodule
